FILE: rtl/dfa_transition_composer_assert.svh
// Assertion macros shared by the transition composer RTL.
// Each file that checks its own logic includes this header; the macros use clk and rst.
`ifndef DFA_TRANSITION_COMPOSER_ASSERT_SVH
`define DFA_TRANSITION_COMPOSER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define DTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dtc_pkg.sv
// Shared types, constants and map functions for the transition composer.
// No dependencies; used by every module of the block.
package dtc_pkg;

  localparam int MAP_W         = 64;
  localparam int NIBBLE_W      = 4;
  localparam int MAX_STATES    = 16;
  localparam int NUM_STATES    = 16;
  localparam int ALPHABET_SIZE = 256;
  localparam int FUNC_W        = 2;
  localparam int SYM_W         = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried in tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FEED   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  // One queued operation: a feed with its table row, or a finish marker
  typedef struct packed {
    logic             feed;
    logic [MAP_W-1:0] row;
  } dtc_entry_t;

  // Identity map: nibble i holds i below NUM_STATES, zero above
  function automatic logic [MAP_W-1:0] identity_map();
    logic [MAP_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (i < NUM_STATES) begin
        m[i*NIBBLE_W +: NIBBLE_W] = NIBBLE_W'(i);
      end
    end
    return m;
  endfunction

  // new[i] = row[map[i]] for every live state, sixteen independent muxes
  function automatic logic [MAP_W-1:0] compose_map(logic [MAP_W-1:0] row,
                                                   logic [MAP_W-1:0] map);
    logic [MAP_W-1:0]    r;
    logic [NIBBLE_W-1:0] sel;
    r = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      sel = map[i*NIBBLE_W +: NIBBLE_W];
      if (i < NUM_STATES) begin
        r[i*NIBBLE_W +: NIBBLE_W] = row[{sel, 2'b00} +: NIBBLE_W];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/dfa_transition_composer.sv
// Top level of the transition composer: front end, operation queue, back end.
// Depends on dtc_pkg, dtc_front, dtc_queue and dtc_back.
//
// Runs a 16-state automaton over a byte stream for all start states at once. It sustains
// one transaction per cycle of any kind (load, feed, finish) while the queue has room. A
// load writes its table row at acceptance, so a feed of the same symbol in the very next
// cycle already sees it. A feed reads its row from the single-port table into a register,
// passes a four-entry queue and is composed into the running map in the back end; a finish
// leaves the queue behind every earlier feed and loads its map into the output register.
// When the output is stalled, feeds ahead of a waiting finish keep draining; input stops
// once queue and read stage hold four entries. Rows must be loaded before they are fed.
module dfa_transition_composer #(
  parameter int ALPHABET_SIZE = dtc_pkg::ALPHABET_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [7:0] byte_value, [71:8] row_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] composed_map
);

  logic                          push;
  dtc_pkg::dtc_entry_t           push_entry;
  logic                          pop;
  logic                          q_valid;
  dtc_pkg::dtc_entry_t           q_entry;
  logic [dtc_pkg::QCNT_W-1:0]    q_count;

  // Accept, classify, table access
  dtc_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .func       (s_axis_tuser),
    .byte_value (s_axis_tdata[7:0]),
    .row_data   (s_axis_tdata[71:8]),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue
  dtc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_count    (q_count)
  );

  // Composition and result
  dtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: rtl/dtc_front.sv
// Front end: accepts input transactions, writes table rows, reads the row for a feed.
// Depends on dtc_pkg; pushes feed and finish operations toward dtc_queue.
module dtc_front #(
  parameter int ALPHABET_SIZE = dtc_pkg::ALPHABET_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtc_pkg::FUNC_W-1:0]    func,
  input  logic [dtc_pkg::SYM_W-1:0]     byte_value,
  input  logic [dtc_pkg::MAP_W-1:0]     row_data,
  input  logic [dtc_pkg::QCNT_W-1:0]    q_count,
  output logic                          push,
  output dtc_pkg::dtc_entry_t           push_entry
);

  localparam int ADDR_W = $clog2(ALPHABET_SIZE);
  localparam logic [dtc_pkg::SYM_W:0] SYM_LIMIT = (dtc_pkg::SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [dtc_pkg::QCNT_W-1:0] Q_LIMIT = dtc_pkg::QCNT_W'(dtc_pkg::QUEUE_DEPTH);

  logic [dtc_pkg::MAP_W-1:0] row_mem [ALPHABET_SIZE];
  logic [dtc_pkg::MAP_W-1:0] rd_row;
  logic                      s1_valid;
  logic                      s1_feed;
  logic                      accept;
  logic                      in_range;
  logic                      is_load;
  logic                      is_feed;
  logic                      is_finish;
  logic [ADDR_W-1:0]         addr;

  // Room check counts queued entries plus the one in the read stage
  assign in_ready  = (q_count + dtc_pkg::QCNT_W'(s1_valid)) < Q_LIMIT;
  assign accept    = in_valid && in_ready;
  assign in_range  = {1'b0, byte_value} < SYM_LIMIT;
  assign is_load   = (func == dtc_pkg::FUNC_LOAD);
  assign is_feed   = (func == dtc_pkg::FUNC_FEED);
  assign is_finish = (func == dtc_pkg::FUNC_FINISH);
  assign addr      = byte_value[ADDR_W-1:0];

  // Transition table: one write port for loads, one registered read for feeds
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      row_mem[addr] <= row_data;
    end
    if (accept && is_feed) begin
      rd_row <= row_mem[addr];
    end
  end

  // Read stage control; loads and unused codes end here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_feed  <= 1'b0;
    end else begin
      s1_valid <= accept && (is_finish || (is_feed && in_range));
      s1_feed  <= is_feed;
    end
  end

  assign push            = s1_valid;
  assign push_entry.feed = s1_feed;
  assign push_entry.row  = rd_row;

endmodule

FILE: rtl/dtc_queue.sv
// Short FIFO of classified operations between the front and back ends.
// Depends on dtc_pkg for the entry type and depth.
`include "dfa_transition_composer_assert.svh"

module dtc_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  dtc_pkg::dtc_entry_t        push_entry,
  input  logic                       pop,
  output logic                       q_valid,
  output dtc_pkg::dtc_entry_t        q_entry,
  output logic [dtc_pkg::QCNT_W-1:0] q_count
);

  localparam logic [dtc_pkg::QPTR_W-1:0] LAST_PTR = dtc_pkg::QPTR_W'(dtc_pkg::QUEUE_DEPTH - 1);
  localparam logic [dtc_pkg::QCNT_W-1:0] FULL_CNT = dtc_pkg::QCNT_W'(dtc_pkg::QUEUE_DEPTH);

  dtc_pkg::dtc_entry_t         slots [dtc_pkg::QUEUE_DEPTH];
  logic [dtc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [dtc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [dtc_pkg::QCNT_W-1:0]  count;

  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];
  assign q_count = count;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DTC_ASSERT_IMP(a_no_overflow, push && !pop, count < FULL_CNT, "queue overflow")
  `DTC_ASSERT_IMP(a_no_underflow, pop, count != '0, "queue underflow")

endmodule

FILE: rtl/dtc_back.sv
// Back end: composes table rows into the running map and emits it on finish.
// Depends on dtc_pkg for the map functions; drains dtc_queue.
`include "dfa_transition_composer_assert.svh"

module dtc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  dtc_pkg::dtc_entry_t       q_entry,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dtc_pkg::MAP_W-1:0] out_data
);

  logic [dtc_pkg::MAP_W-1:0] map;
  logic                      emit;

  // Feeds always drain; a finish waits for a free output register
  assign pop  = q_valid && (q_entry.feed || !out_valid || out_ready);
  assign emit = pop && !q_entry.feed;

  // Running map
  always_ff @(posedge clk) begin
    if (rst) begin
      map <= dtc_pkg::identity_map();
    end else if (pop) begin
      map <= q_entry.feed ? dtc_pkg::compose_map(q_entry.row, map)
                          : dtc_pkg::identity_map();
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= map;
    end
  end

  `DTC_ASSERT_NXT(a_finish_resets_map, emit, map == dtc_pkg::identity_map(), "map not reset")
  `DTC_ASSERT_NXT(a_finish_emits, emit, out_valid, "finish produced no result")

endmodule

FILE: verif/tb.sv
// Testbench for dfa_transition_composer: loads table rows, streams symbols, checks each map.
// Needs dtc_pkg and the composer RTL; the expected maps come from a local state-map tracker.
`timescale 1ns / 100ps

module tb;

  // func 3 is unused by the block and must not change anything
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [63:0] START_MAP   = 64'hFEDC_BA98_7654_3210;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // [7:0] byte_value, [71:8] row_data
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] composed_map

  dfa_transition_composer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Tracker state: table copy, which rows hold data, and the running state map
  logic [63:0] row_store [256];
  bit          row_loaded [256];
  byte unsigned loaded_syms [$];
  logic [63:0] state_map = START_MAP;
  logic [63:0] pending_maps [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int maps_checked = 0;
  int feeds_sent   = 0;

  // Sender burst control
  bit tx_gaps    = 1'b1;
  int burst_left = 0;

  // Receiver long hold-off requests
  int hold_requests = 0;
  int hold_len      = 0;

  // new[i] = row[map[i]] for all sixteen start states
  function automatic logic [63:0] advance_map(logic [63:0] row, logic [63:0] cur);
    logic [63:0] nxt;
    logic [3:0]  sel;
    nxt = '0;
    for (int i = 0; i < 16; i++) begin
      sel = cur[4*i +: 4];
      nxt[4*i +: 4] = row[4*sel +: 4];
    end
    return nxt;
  endfunction

  // Update the tracker for one accepted transaction
  task automatic track_item(logic [1:0] func, logic [7:0] sym, logic [63:0] row);
    case (func)
      dtc_pkg::FUNC_LOAD: begin
        row_store[sym] = row;
        if (!row_loaded[sym]) loaded_syms.push_back(sym);
        row_loaded[sym] = 1'b1;
      end
      dtc_pkg::FUNC_FEED: begin
        state_map = advance_map(row_store[sym], state_map);
        feeds_sent++;
      end
      dtc_pkg::FUNC_FINISH: begin
        pending_maps.push_back(state_map);
        state_map = START_MAP;
      end
      default: ;
    endcase
  endtask

  // Offer one transaction and hold it until the handshake completes
  task automatic send_item(logic [1:0] func, logic [7:0] sym, logic [63:0] row);
    if (tx_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, sym};
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
    track_item(func, sym, row);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [63:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_loaded();
    return loaded_syms[$urandom_range(loaded_syms.size() - 1)];
  endfunction

  // Receiver: segments of random readiness, plus long hold-offs on request
  initial begin : rx_pattern
    int seg_left  = 0;
    int ready_pct = 100;
    int hold_left = 0;
    int served    = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 40);
          case ($urandom_range(3))
            0: ready_pct = 0;
            1: ready_pct = 30;
            2: ready_pct = 70;
            default: ready_pct = 100;
          endcase
        end
        seg_left--;
        m_axis_tready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  // Compare every output transaction with the oldest pending map
  always @(posedge clk) begin : check_maps
    logic [63:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_maps.size() == 0) begin
        $error("composed_map: no map pending, actual %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        if (m_axis_tdata !== want) begin
          $error("composed_map: expected %h, actual %h", want, m_axis_tdata);
          fail_count++;
        end
        maps_checked++;
      end
    end
  end

  // Finish with no feeds gives identity, also back to back
  task automatic test_identity_finish();
    send_item(dtc_pkg::FUNC_FINISH, 8'h00, 64'h0);
    send_item(dtc_pkg::FUNC_FINISH, 8'hFF, '1);
  endtask

  // Extreme rows and symbols, feed right after load, permutations
  task automatic test_directed_rows();
    send_item(dtc_pkg::FUNC_LOAD, 8'h00, 64'h0);
    send_item(dtc_pkg::FUNC_LOAD, 8'hFF, '1);
    send_item(dtc_pkg::FUNC_FEED, 8'hFF, 64'h0);
    send_item(dtc_pkg::FUNC_FEED, 8'h00, '1);
    send_item(dtc_pkg::FUNC_FINISH, 8'h00, 64'h0);
    // reversal applied twice is identity; feed follows its load directly
    send_item(dtc_pkg::FUNC_LOAD, 8'hA5, 64'h0123_4567_89AB_CDEF);
    send_item(dtc_pkg::FUNC_FEED, 8'hA5, rand_row());
    send_item(dtc_pkg::FUNC_FEED, 8'hA5, rand_row());
    send_item(dtc_pkg::FUNC_FINISH, 8'h5A, rand_row());
    // rotate by one, then reverse
    send_item(dtc_pkg::FUNC_LOAD, 8'h5A, 64'h0FED_CBA9_8765_4321);
    send_item(dtc_pkg::FUNC_FEED, 8'h5A, 64'h0);
    send_item(dtc_pkg::FUNC_FEED, 8'hA5, 64'h0);
    send_item(dtc_pkg::FUNC_FINISH, 8'hFF, 64'h0);
    // overwrite a row and use the new contents
    send_item(dtc_pkg::FUNC_LOAD, 8'h00, rand_row());
    send_item(dtc_pkg::FUNC_FEED, 8'h00, 64'h0);
    send_item(dtc_pkg::FUNC_FINISH, 8'h00, 64'h0);
  endtask

  // func 3 must leave table and map untouched
  task automatic test_unused_func();
    send_item(dtc_pkg::FUNC_FEED, 8'h5A, 64'h0);
    send_item(FUNC_UNUSED, 8'hFF, '1);
    send_item(FUNC_UNUSED, 8'h00, 64'h0);
    send_item(dtc_pkg::FUNC_FEED, 8'hA5, 64'h0);
    send_item(dtc_pkg::FUNC_FINISH, 8'h00, 64'h0);
  endtask

  // Random symbol streams with occasional reloads, finishes and unused codes
  task automatic test_random_stream(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      // a stretch without sender gaps in the middle
      tx_gaps = !(n >= count / 3 && n < count / 2);
      pick = $urandom_range(99);
      if (pick < 10)
        send_item(dtc_pkg::FUNC_LOAD, 8'($urandom), rand_row());
      else if (pick < 77)
        send_item(dtc_pkg::FUNC_FEED, pick_loaded(), rand_row());
      else if (pick < 95)
        send_item(dtc_pkg::FUNC_FINISH, 8'($urandom), rand_row());
      else
        send_item(FUNC_UNUSED, 8'($urandom), rand_row());
    end
    tx_gaps = 1'b1;
  endtask

  // Output held off for a long stretch while feeds and finishes keep coming
  task automatic test_output_backpressure();
    tx_gaps       = 1'b0;
    hold_len      = 200;
    hold_requests = hold_requests + 1;
    for (int n = 0; n < 40; n++) begin
      if (n % 4 == 3)
        send_item(dtc_pkg::FUNC_FINISH, 8'($urandom), rand_row());
      else
        send_item(dtc_pkg::FUNC_FEED, pick_loaded(), rand_row());
    end
    tx_gaps = 1'b1;
  endtask

  // Main sequence
  initial begin : run_tests
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_identity_finish();
    test_directed_rows();
    test_unused_func();
    test_random_stream(500);
    test_output_backpressure();
    test_random_stream(40);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_maps.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_maps.size() != 0) begin
      $error("composed_map: %0d maps never arrived", pending_maps.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions (%0d feeds, %0d table rows loaded), checked %0d maps.",
             items_sent, feeds_sent, loaded_syms.size(), maps_checked);
    $display("Covered identity finishes, extreme rows, unused func, random streams, hold-off.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("Timeout with %0d maps pending", pending_maps.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
